// ===== hw/rtl/rttbfa_pkg.sv =====
`timescale 1ns / 1ps

package rttbfa_pkg;

  localparam int unsigned TIME_W     = 32;
  localparam int unsigned PCT_W      = 7;
  localparam int unsigned FRAC_W     = 4;
  localparam int unsigned AVG_W      = 36;
  localparam int unsigned IN_DATA_W  = 64;
  localparam int unsigned OUT_DATA_W = 72;
  localparam int unsigned NUM_LANES  = 2;
  localparam int unsigned LANE_LINK  = 0;
  localparam int unsigned LANE_TRANS = 1;

  localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

  // floor(x / 100) = (x * RECIP_MUL) >> RECIP_SHIFT, exact for x < 43690
  localparam int unsigned RECIP_W     = 14;
  localparam int unsigned RECIP_SHIFT = 20;
  localparam logic [RECIP_W-1:0] RECIP_MUL = 14'd10486;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SUM  = 4'b0010,
    ST_SEL  = 4'b0100,
    ST_DIV  = 4'b1000
  } state_e;

endpackage

// ===== hw/rtl/rtt_history_best_fraction_average_unit.sv =====
`timescale 1ns / 1ps
// Operation: a summing pass over the N entries when K > N/2, then P = min(K, N-K) selection
//   passes over the N entries, then one quotient bit per cycle (the last bit waits for a free output
//   register) over 36 + clog2(N) bits (N = HISTORY_DEPTH).
// Throughput: one request at a time; the next is taken once the result sits in the output register.
// Reset: both histories to their defaults, best_percent to 100, no result pending.

module rtt_history_best_fraction_average_unit #(
  parameter int unsigned HISTORY_DEPTH = 16,
  parameter int unsigned LINK_DEFAULT  = 200,
  parameter int unsigned TRANS_DEFAULT = 200
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [6:0]  cfg_wdata_i,      // best_percent
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,   // send_time, receive_time
  input  logic        s_axis_tuser_i,   // first_transmission
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [71:0] m_axis_tdata_o    // link_average, trans_average
);

  localparam int unsigned TW = rttbfa_pkg::TIME_W;
  localparam int unsigned AW = rttbfa_pkg::AVG_W;
  localparam int unsigned FW = rttbfa_pkg::FRAC_W;
  localparam int unsigned NL = rttbfa_pkg::NUM_LANES;
  localparam int unsigned IW = $clog2(HISTORY_DEPTH);
  localparam int unsigned KW = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned SW = TW + IW;
  localparam int unsigned DW = SW + FW;
  localparam int unsigned CW = $clog2(DW);
  localparam int unsigned XW = $clog2(HISTORY_DEPTH * 100 + 100);
  localparam int unsigned PW = XW + rttbfa_pkg::RECIP_W;

  localparam logic [KW:0]   DEPTH_K   = (KW + 1)'(HISTORY_DEPTH);
  localparam logic [IW-1:0] CNT_LAST  = IW'(HISTORY_DEPTH - 1);
  localparam logic [CW-1:0] DIV_LAST  = CW'(DW - 1);

  rttbfa_pkg::state_e state_q, state_d;

  logic [TW-1:0] hist_q   [NL][HISTORY_DEPTH];
  logic [TW-1:0] hist_new [NL][HISTORY_DEPTH];
  logic [TW-1:0] buf_q    [NL][HISTORY_DEPTH];
  logic [TW-1:0] carry_q  [NL];
  logic [SW-1:0] acc_q    [NL];
  logic [DW-1:0] quo_q    [NL];
  logic [KW-1:0] rem_q    [NL];
  logic [AW-1:0] out_q    [NL];

  logic [TW-1:0] head     [NL];
  logic [TW-1:0] lo_val   [NL];
  logic [TW-1:0] hi_val   [NL];
  logic [TW-1:0] sel_val  [NL];
  logic [TW-1:0] tail_val [NL];
  logic [SW-1:0] acc_sum  [NL];
  logic [SW-1:0] acc_sel  [NL];
  logic [KW:0]   rem_sh   [NL];
  logic          rem_ge   [NL];
  logic [KW-1:0] rem_nx   [NL];
  logic [DW-1:0] quo_nx   [NL];

  logic [IW-1:0] cnt_q, cnt_d;
  logic [KW-1:0] pass_cnt_q, pass_cnt_d;
  logic [CW-1:0] dcnt_q, dcnt_d;
  logic [KW-1:0] k_q, pass_q;
  logic          use_min_q;
  logic          out_valid_q, out_valid_d;

  logic [TW-1:0] rtt;
  logic [TW-1:0] carry_init;
  logic          in_acc, cnt_last, div_last, out_free, div_step, div_load, pass_last;

  logic [6:0]    pct_eff;
  logic [XW-1:0] frac_x;
  logic [PW-1:0] frac_prod;
  logic [KW-1:0] k_cfg, pass_cfg;
  logic          min_cfg;

  // best_percent -> K, pass count and direction
  always_comb begin
    if (cfg_wdata_i == '0 || cfg_wdata_i > rttbfa_pkg::PCT_FULL) begin
      pct_eff = rttbfa_pkg::PCT_FULL;
    end else begin
      pct_eff = cfg_wdata_i;
    end
    frac_x    = XW'(HISTORY_DEPTH) * XW'(pct_eff) + XW'(rttbfa_pkg::PCT_FULL - 7'd1);
    frac_prod = PW'(frac_x) * PW'(rttbfa_pkg::RECIP_MUL);
    k_cfg     = KW'(frac_prod >> rttbfa_pkg::RECIP_SHIFT);
    min_cfg   = ({k_cfg, 1'b0} <= DEPTH_K);
    pass_cfg  = min_cfg ? k_cfg : (KW'(HISTORY_DEPTH) - k_cfg);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q       <= KW'(HISTORY_DEPTH);
      pass_q    <= '0;
      use_min_q <= 1'b0;
    end else if (cfg_we_i) begin
      k_q       <= k_cfg;
      pass_q    <= pass_cfg;
      use_min_q <= min_cfg;
    end
  end

  assign s_axis_tready_o = (state_q == rttbfa_pkg::ST_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign rtt             = s_axis_tdata_i[63:32] - s_axis_tdata_i[31:0];
  assign carry_init      = use_min_q ? '1 : '0;

  always_comb begin
    for (int l = 0; l < NL; l++) begin
      if (l == rttbfa_pkg::LANE_LINK && !s_axis_tuser_i) begin
        for (int i = 0; i < HISTORY_DEPTH; i++) begin
          hist_new[l][i] = hist_q[l][i];
        end
      end else begin
        for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
          hist_new[l][i] = hist_q[l][i+1];
        end
        hist_new[l][HISTORY_DEPTH-1] = rtt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        hist_q[rttbfa_pkg::LANE_LINK][i]  <= TW'(LINK_DEFAULT);
        hist_q[rttbfa_pkg::LANE_TRANS][i] <= TW'(TRANS_DEFAULT);
      end
    end else if (in_acc) begin
      hist_q <= hist_new;
    end
  end

  // shared compare / add / divide step, one per lane
  always_comb begin
    for (int l = 0; l < NL; l++) begin
      head[l]     = buf_q[l][0];
      lo_val[l]   = (carry_q[l] < head[l]) ? carry_q[l] : head[l];
      hi_val[l]   = (carry_q[l] < head[l]) ? head[l] : carry_q[l];
      sel_val[l]  = use_min_q ? lo_val[l] : hi_val[l];
      tail_val[l] = use_min_q ? hi_val[l] : lo_val[l];
      acc_sum[l]  = acc_q[l] + SW'(head[l]);
      acc_sel[l]  = use_min_q ? (acc_q[l] + SW'(sel_val[l])) : (acc_q[l] - SW'(sel_val[l]));
      rem_sh[l]   = {rem_q[l], quo_q[l][DW-1]};
      rem_ge[l]   = (rem_sh[l] >= {1'b0, k_q});
      rem_nx[l]   = rem_ge[l] ? KW'(rem_sh[l] - {1'b0, k_q}) : rem_sh[l][KW-1:0];
      quo_nx[l]   = {quo_q[l][DW-2:0], rem_ge[l]};
    end
  end

  assign cnt_last  = (cnt_q == CNT_LAST);
  assign div_last  = (dcnt_q == DIV_LAST);
  assign pass_last = (pass_cnt_q == pass_q - KW'(1));
  assign out_free  = !out_valid_q || m_axis_tready_i;
  assign div_step  = (state_q == rttbfa_pkg::ST_DIV) && (!div_last || out_free);
  assign div_load  = cnt_last && (((state_q == rttbfa_pkg::ST_SUM) && (pass_q == '0)) ||
                                  ((state_q == rttbfa_pkg::ST_SEL) && pass_last));

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    pass_cnt_d  = pass_cnt_q;
    dcnt_d      = dcnt_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    case (state_q)
      rttbfa_pkg::ST_IDLE: begin
        if (in_acc) begin
          cnt_d      = '0;
          pass_cnt_d = '0;
          state_d    = use_min_q ? rttbfa_pkg::ST_SEL : rttbfa_pkg::ST_SUM;
        end
      end
      rttbfa_pkg::ST_SUM: begin
        cnt_d = cnt_q + IW'(1);
        if (cnt_last) begin
          cnt_d = '0;
          if (pass_q == '0) begin
            dcnt_d  = '0;
            state_d = rttbfa_pkg::ST_DIV;
          end else begin
            state_d = rttbfa_pkg::ST_SEL;
          end
        end
      end
      rttbfa_pkg::ST_SEL: begin
        cnt_d = cnt_q + IW'(1);
        if (cnt_last) begin
          cnt_d      = '0;
          pass_cnt_d = pass_cnt_q + KW'(1);
          if (pass_last) begin
            dcnt_d  = '0;
            state_d = rttbfa_pkg::ST_DIV;
          end
        end
      end
      rttbfa_pkg::ST_DIV: begin
        if (!div_last) begin
          dcnt_d = dcnt_q + CW'(1);
        end else if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = rttbfa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = rttbfa_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rttbfa_pkg::ST_IDLE;
      cnt_q       <= '0;
      pass_cnt_q  <= '0;
      dcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      pass_cnt_q  <= pass_cnt_d;
      dcnt_q      <= dcnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // working copies rotate past the compare unit; extracted entries become the neutral value
  always_ff @(posedge clk_i) begin
    for (int l = 0; l < NL; l++) begin
      case (state_q)
        rttbfa_pkg::ST_IDLE: begin
          if (in_acc) begin
            buf_q[l]   <= hist_new[l];
            acc_q[l]   <= '0;
            carry_q[l] <= carry_init;
          end
        end
        rttbfa_pkg::ST_SUM: begin
          for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
            buf_q[l][i] <= buf_q[l][i+1];
          end
          buf_q[l][HISTORY_DEPTH-1] <= head[l];
          acc_q[l] <= acc_sum[l];
          if (div_load) begin
            quo_q[l] <= {acc_sum[l], FW'(0)};
            rem_q[l] <= '0;
          end
        end
        rttbfa_pkg::ST_SEL: begin
          for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
            buf_q[l][i] <= buf_q[l][i+1];
          end
          buf_q[l][HISTORY_DEPTH-1] <= tail_val[l];
          carry_q[l] <= cnt_last ? carry_init : sel_val[l];
          if (cnt_last) begin
            acc_q[l] <= acc_sel[l];
          end
          if (div_load) begin
            quo_q[l] <= {acc_sel[l], FW'(0)};
            rem_q[l] <= '0;
          end
        end
        rttbfa_pkg::ST_DIV: begin
          if (div_step) begin
            quo_q[l] <= quo_nx[l];
            rem_q[l] <= rem_nx[l];
          end
          if (div_last && out_free) begin
            out_q[l] <= quo_nx[l][AW-1:0];
          end
        end
        default: begin
          carry_q[l] <= carry_init;
        end
      endcase
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_q[rttbfa_pkg::LANE_TRANS], out_q[rttbfa_pkg::LANE_LINK]};

  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !s_axis_tready_o)
    else $error("request taken while busy");

  a_k_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (k_q != '0) && ({1'b0, k_q} <= DEPTH_K))
    else $error("fraction count out of range");

  a_pass_half: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {pass_q, 1'b0} <= DEPTH_K)
    else $error("selection pass count above half depth");

  a_sel_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rttbfa_pkg::ST_SEL) |-> (pass_q != '0) && (pass_cnt_q < pass_q))
    else $error("selection pass counter overrun");

  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == rttbfa_pkg::ST_DIV))
    else $error("result raised outside divide");

endmodule
